// ===== hdl/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam int unsigned CHAIN_WORDS = 5;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS = 80;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_CLOAD,
		ST_ROUND,
		ST_CUPD,
		ST_EMIT
	} state_t;

	// Controls for the round datapath.
	typedef struct packed {
		logic       shift;
		logic       round;
		logic [6:0] t;
	} rnd_ctl_t;

	function automatic logic [31:0] chain_init(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = H0_INIT;
			3'd1:    v = H1_INIT;
			3'd2:    v = H2_INIT;
			3'd3:    v = H3_INIT;
			3'd4:    v = H4_INIT;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = K0;
		end else if (t < 7'd40) begin
			k = K1;
		end else if (t < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	// Byte idx (0 = most significant) of the message length in bits.
	function automatic logic [7:0] len_byte(input logic [63:0] total, input logic [2:0] idx);
		logic [63:0] bits;
		bits = {total[60:0], 3'b000};
		return 8'(bits >> {~idx, 3'b000});
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sha1_buf.sv =====
`default_nettype none

module sha1_buf (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [3:0]  waddr,
	input  wire logic [31:0] wdata,
	input  wire logic [3:0]  raddr,
	output logic      [31:0] rdata_q
);
	import sha1_pkg::*;

	logic [31:0] mem [BLOCK_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/sha1_chain.sv =====
`default_nettype none

module sha1_chain (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        clear,
	input  wire logic        re,
	input  wire logic [2:0]  raddr,
	input  wire logic        we,
	input  wire logic [2:0]  waddr,
	input  wire logic [31:0] wdata,
	output logic      [31:0] rdata_q
);
	import sha1_pkg::*;

	logic [31:0]            mem [CHAIN_WORDS];
	logic [CHAIN_WORDS-1:0] vld_q;

	// An entry that has not been written since reset or the last digest reads
	// as its initial chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem[raddr] : chain_init(raddr);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sha1_round.sv =====
`default_nettype none

module sha1_round (
	input  wire logic               clk,
	input  wire sha1_pkg::rnd_ctl_t ctl,
	input  wire logic [31:0]        shift_in,
	input  wire logic [31:0]        mem_word,
	output logic      [31:0]        a_o
);
	import sha1_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] win_q [BLOCK_WORDS];
	logic [31:0] w_mix, w_sched, w_t, tmp;

	// win_q[15] holds the newest schedule word, win_q[0] the one from 16 rounds ago.
	assign w_mix   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_sched = {w_mix[30:0], w_mix[31]};
	assign w_t     = (ctl.t < 7'd16) ? mem_word : w_sched;
	assign tmp     = {a_q[26:0], a_q[31:27]} + round_f(ctl.t, b_q, c_q, d_q) + e_q
	                 + round_k(ctl.t) + w_t;
	assign a_o     = a_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
			e_q <= shift_in;
		end else if (ctl.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BLOCK_WORDS-1] <= w_t;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sha1_hash_engine.sv =====
`default_nettype none

// SHA-1 engine fed one message byte per input beat. A beat with tuser low absorbs
// the byte in tdata; a beat with tuser high finishes the message, pads it and
// returns the five digest words h0..h4 as five output beats (tuser gives the word
// index, tlast marks h4), after which a new message may start at once. After every
// 64th absorbed byte, input stalls while the compression runs: it reads the five
// chaining words from their memory, runs 80 rounds at one per cycle, and adds the
// result back. A finish beat writes the padding and length one byte per cycle (9 to
// 72 bytes), runs one or two compressions, and then reads each digest word from the
// chaining memory before loading it into the output register.
module sha1_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
	input  wire logic [0:0]  s_tuser,   // op[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // digest_word[31:0]
	output logic      [2:0]  m_tuser,   // word_index[2:0]
	output logic             m_tlast    // word_last
);
	import sha1_pkg::*;

	localparam logic [6:0] SEQ_LAST   = 7'(CHAIN_WORDS);
	localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
	localparam logic [6:0] EMIT_LAST  = 7'(CHAIN_WORDS - 1);

	state_t      state_q, state_d;
	logic [6:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [23:0] pack_q;
	logic [63:0] total_q;
	logic        fin_q, mark_q, len_blk_q, pend_q;

	logic        push_en;
	logic [7:0]  push_byte, pad_byte;
	logic        absorb_acc, finish_acc;
	logic        buf_we;
	logic [3:0]  buf_raddr;
	logic [31:0] buf_rdata;
	logic        ch_re, ch_we, ch_clear;
	logic [2:0]  ch_raddr, ch_waddr;
	logic [31:0] ch_rdata, ch_wdata, a_w;
	rnd_ctl_t    rnd_ctl;
	logic        out_free, emit_load;

	assign absorb_acc = s_tvalid && s_tready && (s_tuser[0] == OP_ABSORB);
	assign finish_acc = s_tvalid && s_tready && (s_tuser[0] == OP_FINISH);
	assign out_free   = !m_tvalid || m_tready;

	// The length goes into bytes 56..63 of the block in which len_blk_q is set.
	assign pad_byte = !mark_q ? PAD_MARK :
	                  (len_blk_q && fill_q[5:3] == 3'b111) ? len_byte(total_q, fill_q[2:0]) :
	                  8'h00;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (finish_acc) begin
					state_d = ST_PAD;
				end else if (absorb_acc && fill_q == 6'd63) begin
					state_d = ST_CLOAD;
				end
			end
			ST_PAD: begin
				if (fill_q == 6'd63) begin
					state_d = ST_CLOAD;
				end
			end
			ST_CLOAD: begin
				if (cnt_q == SEQ_LAST) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (cnt_q == ROUND_LAST) begin
					state_d = ST_CUPD;
				end
			end
			ST_CUPD: begin
				if (cnt_q == SEQ_LAST) begin
					if (!fin_q) begin
						state_d = ST_IDLE;
					end else if (len_blk_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_EMIT: begin
				if (pend_q && out_free && cnt_q == EMIT_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		push_en       = 1'b0;
		push_byte     = pad_byte;
		ch_re         = 1'b0;
		ch_raddr      = cnt_q[2:0];
		ch_we         = 1'b0;
		ch_waddr      = 3'(cnt_q - 7'd1);
		ch_wdata      = ch_rdata + a_w;
		ch_clear      = 1'b0;
		buf_raddr     = '0;
		rnd_ctl.shift = 1'b0;
		rnd_ctl.round = 1'b0;
		rnd_ctl.t     = cnt_q;
		emit_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				push_en   = absorb_acc;
				push_byte = s_tdata;
			end
			ST_PAD: begin
				push_en = 1'b1;
			end
			ST_CLOAD: begin
				ch_re         = cnt_q < SEQ_LAST;
				rnd_ctl.shift = cnt_q != 7'd0;
			end
			ST_ROUND: begin
				rnd_ctl.round = 1'b1;
				buf_raddr     = 4'(cnt_q + 7'd1);
			end
			ST_CUPD: begin
				ch_re         = cnt_q < SEQ_LAST;
				ch_we         = cnt_q != 7'd0;
				rnd_ctl.shift = cnt_q != 7'd0;
			end
			ST_EMIT: begin
				ch_re     = !pend_q;
				emit_load = pend_q && out_free;
				ch_clear  = emit_load && cnt_q == EMIT_LAST;
			end
			default: begin
			end
		endcase
	end

	assign buf_we = push_en && fill_q[1:0] == 2'b11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			fin_q     <= 1'b0;
			mark_q    <= 1'b0;
			len_blk_q <= 1'b0;
			pend_q    <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == ST_CLOAD || state_q == ST_ROUND || state_q == ST_CUPD
			             || emit_load) begin
				cnt_q <= cnt_q + 7'd1;
			end

			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (absorb_acc) begin
				total_q <= total_q + 64'd1;
			end

			if (finish_acc) begin
				fin_q     <= 1'b1;
				mark_q    <= 1'b0;
				len_blk_q <= 1'b0;
			end else if (state_q == ST_PAD && !mark_q) begin
				mark_q <= 1'b1;
				if (fill_q < 6'd56) begin
					len_blk_q <= 1'b1;
				end
			end else if (state_q == ST_CUPD && cnt_q == SEQ_LAST && fin_q) begin
				len_blk_q <= 1'b1;
			end else if (ch_clear) begin
				fin_q     <= 1'b0;
				mark_q    <= 1'b0;
				len_blk_q <= 1'b0;
				total_q   <= '0;
			end

			if (state_q == ST_EMIT && ch_re) begin
				pend_q <= 1'b1;
			end else if (emit_load) begin
				pend_q <= 1'b0;
			end

			if (emit_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en && fill_q[1:0] != 2'b11) begin
			pack_q <= {pack_q[15:0], push_byte};
		end
		if (emit_load) begin
			m_tdata <= ch_rdata;
			m_tuser <= cnt_q[2:0];
			m_tlast <= cnt_q == EMIT_LAST;
		end
	end

	sha1_buf u_buf (
		.clk     (clk),
		.we      (buf_we),
		.waddr   (fill_q[5:2]),
		.wdata   ({pack_q, push_byte}),
		.raddr   (buf_raddr),
		.rdata_q (buf_rdata)
	);

	sha1_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (ch_clear),
		.re      (ch_re),
		.raddr   (ch_raddr),
		.we      (ch_we),
		.waddr   (ch_waddr),
		.wdata   (ch_wdata),
		.rdata_q (ch_rdata)
	);

	sha1_round u_round (
		.clk      (clk),
		.ctl      (rnd_ctl),
		.shift_in (ch_rdata),
		.mem_word (buf_rdata),
		.a_o      (a_w)
	);

endmodule

`default_nettype wire

// ===== test/tb_sha1_hash_engine.sv =====
`default_nettype none

module tb_sha1_hash_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned TAIL_CYCLES = 300;
	localparam int unsigned PHASE_BEATS = 45;

	typedef struct {
		logic       op;
		logic [7:0] data;
	} in_beat_t;

	typedef struct {
		logic [2:0]  idx;
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	sha1_hash_engine DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// Stimulus and expectations.
	in_beat_t     pending_beats[$];
	digest_beat_t digest_q[$];
	int unsigned  beats_queued = 0;
	int unsigned  beats_taken = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  err_count = 0;
	int unsigned  idle_cycles = 0;
	logic         in_took = 1'b0;

	// Predicted hash state.
	logic [31:0]  hash_h [5];
	logic [7:0]   blk [64];
	int unsigned  blk_fill;
	logic [63:0]  msg_bytes;

	function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic reset_hash();
		hash_h[0] = H0_INIT;
		hash_h[1] = H1_INIT;
		hash_h[2] = H2_INIT;
		hash_h[3] = H3_INIT;
		hash_h[4] = H4_INIT;
		blk_fill = 0;
		msg_bytes = '0;
	endtask

	task automatic compress_chunk();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, tmp;
		for (int t = 0; t < 16; t++) begin
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		end
		for (int t = 16; t < 80; t++) begin
			w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
		end
		a = hash_h[0];
		b = hash_h[1];
		c = hash_h[2];
		d = hash_h[3];
		e = hash_h[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			tmp = rol(a, 5) + f + e + k + w[t];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = tmp;
		end
		hash_h[0] += a;
		hash_h[1] += b;
		hash_h[2] += c;
		hash_h[3] += d;
		hash_h[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] v);
		blk[blk_fill] = v;
		blk_fill++;
		if (blk_fill == 64) begin
			compress_chunk();
			blk_fill = 0;
		end
	endtask

	task automatic predict_digest(input logic op, input logic [7:0] v);
		logic [63:0]  bit_len;
		digest_beat_t r;
		if (op == OP_ABSORB) begin
			msg_bytes++;
			absorb_byte(v);
		end else begin
			bit_len = msg_bytes << 3;
			absorb_byte(PAD_MARK);
			while (blk_fill != 56) begin
				absorb_byte(8'h00);
			end
			for (int i = 7; i >= 0; i--) begin
				absorb_byte(bit_len[8*i +: 8]);
			end
			for (int i = 0; i < 5; i++) begin
				r.idx = 3'(i);
				r.word = hash_h[i];
				r.last = (i == 4);
				digest_q.push_back(r);
			end
			reset_hash();
		end
	endtask

	task automatic queue_beat(input logic op, input logic [7:0] v);
		in_beat_t b;
		b.op = op;
		b.data = v;
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	// A message of random bytes followed by its finish beat; the finish carries junk data.
	task automatic queue_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			queue_beat(OP_ABSORB, 8'($urandom_range(255)));
		end
		queue_beat(OP_FINISH, 8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (beats_taken != beats_queued || digest_q.size() != 0);
		@(posedge clk);
	endtask

	// Input driver: a new beat is offered only when the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_took) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_beats[0].data;
				s_tuser <= pending_beats[0].op;
				pending_beats.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor, predictor and watchdog.
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		logic         in_fire;
		logic         out_fire;
		in_fire = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;
		in_took <= in_fire;
		if (out_fire) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest beat: word_index %0d digest_word %08h", m_tuser,
					m_tdata);
				err_count++;
			end else begin
				exp_beat = digest_q.pop_front();
				if (m_tuser !== exp_beat.idx) begin
					$error("word_index: expected %0d, got %0d", exp_beat.idx, m_tuser);
					err_count++;
				end
				if (m_tdata !== exp_beat.word) begin
					$error("digest_word: expected %08h, got %08h", exp_beat.word, m_tdata);
					err_count++;
				end
				if (m_tlast !== exp_beat.last) begin
					$error("word_last: expected %0b, got %0b", exp_beat.last, m_tlast);
					err_count++;
				end
			end
		end
		if (in_fire) begin
			predict_digest(s_tuser[0], s_tdata);
			beats_taken++;
		end
		if (in_fire || out_fire || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned send_pct [4] = '{0, 47, 0, 34};
		int unsigned recv_pct [4] = '{0, 0, 47, 34};
		int unsigned boundary [6] = '{55, 56, 57, 63, 64, 65};
		int unsigned start_beats;
		reset_hash();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			start_beats = beats_queued;
			if (ph == 0) begin
				// Empty message, twice in a row to show the state returns to its start, then short fixed messages.
				queue_beat(OP_FINISH, 8'hFF);
				queue_beat(OP_FINISH, 8'h00);
				queue_beat(OP_ABSORB, 8'h61);
				queue_beat(OP_ABSORB, 8'h62);
				queue_beat(OP_ABSORB, 8'h63);
				queue_beat(OP_FINISH, 8'h00);
				queue_beat(OP_ABSORB, 8'h00);
				queue_beat(OP_FINISH, 8'hAA);
				queue_beat(OP_ABSORB, 8'hFF);
				queue_beat(OP_FINISH, 8'h55);
				queue_beat(OP_ABSORB, 8'hFF);
				queue_beat(OP_ABSORB, 8'h00);
				queue_beat(OP_ABSORB, 8'h5A);
				queue_beat(OP_ABSORB, 8'hA5);
				queue_beat(OP_FINISH, 8'hFF);
				start_beats = beats_queued;
			end
			while (beats_queued - start_beats < PHASE_BEATS) begin
				if ($urandom_range(7) == 0) begin
					queue_message(boundary[$urandom_range(5)]);
				end else begin
					queue_message($urandom_range(12));
				end
			end
			// The next phase starts only after every digest of this one has come back.
			wait_drained();
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0 && digest_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/sha1_pkg.sv
hdl/sha1_buf.sv
hdl/sha1_chain.sv
hdl/sha1_round.sv
hdl/sha1_hash_engine.sv
test/tb_sha1_hash_engine.sv
